>>> hw/rtl/gscd_pkg.sv
package gscd_pkg;

   // Default array limits
   localparam int DEF_MAX_ROWS = 16;
   localparam int DEF_MAX_COLS = 32;

   // Field widths of the item channels and the register port
   localparam int CMD_W    = 2;
   localparam int ROW_W    = 4;
   localparam int COL_W    = 5;
   localparam int DATA_W   = 32;
   localparam int COUNT_W  = 6;
   localparam int CSR_IDX_W = 2;
   localparam int ROWS_REG_W = 5;
   localparam int COLS_REG_W = 6;

   // Register reset values
   localparam logic [ROWS_REG_W-1:0] ROWS_RESET   = 5'd16;
   localparam logic [COLS_REG_W-1:0] COLS_RESET   = 6'd32;
   localparam logic [DATA_W-1:0]     THRESH_RESET = 32'd17;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DROP_THRESHOLD = 2'd2;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RUN  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

   // Iteration counts of the serial square root and divider
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 56;
   localparam int STEP_W     = 6;

   typedef enum logic [4:0] {
      S_IDLE,
      S_READ_OUT,
      S_NRM_CLR,
      S_NRM_RD,
      S_NRM_MUL,
      S_NRM_ACC,
      S_NRM_CMP,
      S_SQRT,
      S_NZ_RD,
      S_NZ_LOAD,
      S_NZ_DIV,
      S_NZ_WR,
      S_NEXT,
      S_DROP,
      S_SH_RD,
      S_SH_WR,
      S_DROP_END,
      S_DOT_CLR,
      S_DOT_RDA,
      S_DOT_RDB,
      S_DOT_MUL,
      S_DOT_ACC,
      S_COEF,
      S_UP_RDA,
      S_UP_RDB,
      S_UP_MUL,
      S_UP_SUB,
      S_UP_WR,
      S_PROJ_NEXT,
      S_FINISH
   } gscd_state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_HOST_READ,
      OP_ACC_CLR,
      OP_SQ_MUL,
      OP_ACC_SQ,
      OP_CAP_A,
      OP_DOT_MUL,
      OP_ACC_DOT,
      OP_COEF,
      OP_UP_MUL,
      OP_UP_SUB,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_READ_DONE,
      OP_RUN_DONE
   } gscd_op_type;

   typedef enum logic [1:0] {
      WSEL_HOST,
      WSEL_UPDATE,
      WSEL_QUOT,
      WSEL_SHIFT
   } gscd_wsel_type;

   typedef struct packed {
      logic          mem_re;
      logic          mem_we;
      logic          host_addr;
      gscd_wsel_type wsel;
      gscd_op_type   op;
   } gscd_cmd_type;

   typedef struct packed {
      logic keep;
      logic out_free;
   } gscd_status_type;

endpackage

>>> hw/rtl/gscd_req_if.sv
interface gscd_req_if;
   logic                               valid;
   logic                               ready;
   logic [gscd_pkg::CMD_W-1:0]         command;
   logic [gscd_pkg::ROW_W-1:0]         row_index;
   logic [gscd_pkg::COL_W-1:0]         col_index;
   logic signed [gscd_pkg::DATA_W-1:0] element_value;

   modport source (output valid, command, row_index, col_index, element_value,
                   input ready);
   modport sink (input valid, command, row_index, col_index, element_value,
                 output ready);
endinterface

>>> hw/rtl/gscd_rsp_if.sv
interface gscd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [gscd_pkg::DATA_W-1:0] read_value;
   logic [gscd_pkg::COUNT_W-1:0]       kept_columns;
   logic [gscd_pkg::COUNT_W-1:0]       independent_count;
   logic                               status;

   modport source (output valid, read_value, kept_columns, independent_count, status,
                   input ready);
   modport sink (input valid, read_value, kept_columns, independent_count, status,
                 output ready);
endinterface

>>> hw/rtl/gscd_controller.sv
module gscd_controller #(
   parameter int MAX_ROWS = gscd_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = gscd_pkg::DEF_MAX_COLS,
   localparam int AW = $clog2(MAX_ROWS * MAX_COLS),
   localparam int RW = $clog2(MAX_ROWS + 1),
   localparam int CW = $clog2(MAX_COLS + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic [gscd_pkg::CMD_W-1:0]           req_command,
   output logic                                 req_ready,
   input  logic                                 csr_write_enable,
   input  logic [gscd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gscd_pkg::DATA_W-1:0]          csr_write_data,
   input  gscd_pkg::gscd_status_type            status,
   output gscd_pkg::gscd_cmd_type               cmd,
   output logic [AW-1:0]                        run_addr,
   output logic [CW-1:0]                        run_kept,
   output logic [CW-1:0]                        run_indep
);

   gscd_pkg::gscd_state_type state_ff, state_in;

   logic [gscd_pkg::ROWS_REG_W-1:0] rows_ff, rows_in;
   logic [gscd_pkg::COLS_REG_W-1:0] cols_ff, cols_in;
   logic [RW-1:0]                   r_ff, r_in;
   logic [RW-1:0]                   i_ff, i_in;
   logic [CW-1:0]                   c_ff, c_in;
   logic [CW-1:0]                   m_ff, m_in;
   logic [CW-1:0]                   k_ff, k_in;
   logic [CW-1:0]                   j_ff, j_in;
   logic [gscd_pkg::STEP_W-1:0]     cnt_ff, cnt_in;
   logic [AW-1:0]                   sa_ff, sa_in;

   logic [RW-1:0] r_clamp;
   logic [CW-1:0] c_clamp;
   logic          last_row;
   logic          accept;
   logic [AW-1:0] addr_k;
   logic [AW-1:0] addr_j;
   logic [AW-1:0] shift_end;

   // Clamp the size registers to the array limits, and a zero size to one
   always_comb begin
      if (rows_ff == '0) begin
         r_clamp = RW'(1);
      end else if (int'(rows_ff) > MAX_ROWS) begin
         r_clamp = RW'(MAX_ROWS);
      end else begin
         r_clamp = RW'(rows_ff);
      end
      if (cols_ff == '0) begin
         c_clamp = CW'(1);
      end else if (int'(cols_ff) > MAX_COLS) begin
         c_clamp = CW'(MAX_COLS);
      end else begin
         c_clamp = CW'(cols_ff);
      end
   end

   assign accept    = req_valid && req_ready;
   assign last_row  = (i_ff == r_ff - RW'(1));
   assign addr_k    = AW'(k_ff) * AW'(MAX_ROWS) + AW'(i_ff);
   assign addr_j    = AW'(j_ff) * AW'(MAX_ROWS) + AW'(i_ff);
   assign shift_end = AW'(c_ff - CW'(1)) * AW'(MAX_ROWS);
   assign run_kept  = c_ff;
   assign run_indep = m_ff;

   // Size registers
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_write_enable) begin
         case (csr_index)
            gscd_pkg::CSR_ROWS_IN_USE: rows_in = csr_write_data[gscd_pkg::ROWS_REG_W-1:0];
            gscd_pkg::CSR_COLS_IN_USE: cols_in = csr_write_data[gscd_pkg::COLS_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gscd_pkg::S_IDLE: begin
            if (accept) begin
               case (req_command)
                  gscd_pkg::CMD_RUN:  state_in = gscd_pkg::S_NRM_CLR;
                  gscd_pkg::CMD_READ: state_in = gscd_pkg::S_READ_OUT;
                  default:            state_in = gscd_pkg::S_IDLE;
               endcase
            end
         end
         gscd_pkg::S_READ_OUT: if (status.out_free) state_in = gscd_pkg::S_IDLE;
         gscd_pkg::S_NRM_CLR:  state_in = gscd_pkg::S_NRM_RD;
         gscd_pkg::S_NRM_RD:   state_in = gscd_pkg::S_NRM_MUL;
         gscd_pkg::S_NRM_MUL:  state_in = gscd_pkg::S_NRM_ACC;
         gscd_pkg::S_NRM_ACC: begin
            state_in = last_row ? gscd_pkg::S_NRM_CMP : gscd_pkg::S_NRM_RD;
         end
         gscd_pkg::S_NRM_CMP: begin
            if (status.keep) begin
               state_in = gscd_pkg::S_SQRT;
            end else if (k_ff == '0) begin
               state_in = gscd_pkg::S_NEXT;
            end else begin
               state_in = gscd_pkg::S_DROP;
            end
         end
         gscd_pkg::S_SQRT: begin
            if (cnt_ff == gscd_pkg::STEP_W'(gscd_pkg::SQRT_STEPS - 1)) begin
               state_in = gscd_pkg::S_NZ_RD;
            end
         end
         gscd_pkg::S_NZ_RD:   state_in = gscd_pkg::S_NZ_LOAD;
         gscd_pkg::S_NZ_LOAD: state_in = gscd_pkg::S_NZ_DIV;
         gscd_pkg::S_NZ_DIV: begin
            if (cnt_ff == gscd_pkg::STEP_W'(gscd_pkg::DIV_STEPS - 1)) begin
               state_in = gscd_pkg::S_NZ_WR;
            end
         end
         gscd_pkg::S_NZ_WR: begin
            state_in = last_row ? gscd_pkg::S_NEXT : gscd_pkg::S_NZ_RD;
         end
         gscd_pkg::S_NEXT: begin
            state_in = (k_ff + CW'(1) < c_ff) ? gscd_pkg::S_DOT_CLR : gscd_pkg::S_FINISH;
         end
         gscd_pkg::S_DROP: begin
            state_in = (k_ff < c_ff - CW'(1)) ? gscd_pkg::S_SH_RD : gscd_pkg::S_DROP_END;
         end
         gscd_pkg::S_SH_RD: state_in = gscd_pkg::S_SH_WR;
         gscd_pkg::S_SH_WR: begin
            state_in = (sa_ff + AW'(1) == shift_end) ? gscd_pkg::S_DROP_END
                                                     : gscd_pkg::S_SH_RD;
         end
         gscd_pkg::S_DROP_END: begin
            state_in = (k_ff < c_ff - CW'(1)) ? gscd_pkg::S_DOT_CLR : gscd_pkg::S_FINISH;
         end
         gscd_pkg::S_DOT_CLR: state_in = gscd_pkg::S_DOT_RDA;
         gscd_pkg::S_DOT_RDA: state_in = gscd_pkg::S_DOT_RDB;
         gscd_pkg::S_DOT_RDB: state_in = gscd_pkg::S_DOT_MUL;
         gscd_pkg::S_DOT_MUL: state_in = gscd_pkg::S_DOT_ACC;
         gscd_pkg::S_DOT_ACC: begin
            state_in = last_row ? gscd_pkg::S_COEF : gscd_pkg::S_DOT_RDA;
         end
         gscd_pkg::S_COEF:   state_in = gscd_pkg::S_UP_RDA;
         gscd_pkg::S_UP_RDA: state_in = gscd_pkg::S_UP_RDB;
         gscd_pkg::S_UP_RDB: state_in = gscd_pkg::S_UP_MUL;
         gscd_pkg::S_UP_MUL: state_in = gscd_pkg::S_UP_SUB;
         gscd_pkg::S_UP_SUB: state_in = gscd_pkg::S_UP_WR;
         gscd_pkg::S_UP_WR: begin
            state_in = last_row ? gscd_pkg::S_PROJ_NEXT : gscd_pkg::S_UP_RDA;
         end
         gscd_pkg::S_PROJ_NEXT: begin
            state_in = (j_ff + CW'(1) == k_ff) ? gscd_pkg::S_NRM_CLR : gscd_pkg::S_DOT_CLR;
         end
         gscd_pkg::S_FINISH: if (status.out_free) state_in = gscd_pkg::S_IDLE;
         default: state_in = gscd_pkg::S_IDLE;
      endcase
   end

   // Counters and run sizes
   always_comb begin
      r_in   = r_ff;
      c_in   = c_ff;
      m_in   = m_ff;
      k_in   = k_ff;
      j_in   = j_ff;
      i_in   = i_ff;
      cnt_in = cnt_ff;
      sa_in  = sa_ff;
      case (state_ff)
         gscd_pkg::S_IDLE: begin
            if (accept && req_command == gscd_pkg::CMD_RUN) begin
               r_in = r_clamp;
               c_in = c_clamp;
               m_in = (int'(c_clamp) >= int'(r_clamp)) ? CW'(int'(c_clamp) - int'(r_clamp))
                                                      : '0;
               k_in = '0;
            end
         end
         gscd_pkg::S_NRM_CLR, gscd_pkg::S_DOT_CLR, gscd_pkg::S_COEF: i_in = '0;
         gscd_pkg::S_NRM_ACC, gscd_pkg::S_DOT_ACC, gscd_pkg::S_UP_WR: i_in = i_ff + RW'(1);
         gscd_pkg::S_NRM_CMP: cnt_in = '0;
         gscd_pkg::S_SQRT: begin
            cnt_in = cnt_ff + gscd_pkg::STEP_W'(1);
            i_in   = '0;
         end
         gscd_pkg::S_NZ_LOAD: cnt_in = '0;
         gscd_pkg::S_NZ_DIV:  cnt_in = cnt_ff + gscd_pkg::STEP_W'(1);
         gscd_pkg::S_NZ_WR:   i_in = i_ff + RW'(1);
         gscd_pkg::S_NEXT: begin
            k_in = k_ff + CW'(1);
            j_in = '0;
         end
         gscd_pkg::S_DROP: begin
            if (k_ff <= m_ff) m_in = m_ff - CW'(1);
            sa_in = AW'(k_ff) * AW'(MAX_ROWS);
         end
         gscd_pkg::S_SH_WR: sa_in = sa_ff + AW'(1);
         gscd_pkg::S_DROP_END: begin
            c_in = c_ff - CW'(1);
            j_in = '0;
         end
         gscd_pkg::S_PROJ_NEXT: j_in = j_ff + CW'(1);
         default: ;
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd           = '0;
      cmd.wsel      = gscd_pkg::WSEL_HOST;
      cmd.op        = gscd_pkg::OP_NONE;
      run_addr      = addr_k;
      req_ready     = 1'b0;
      case (state_ff)
         gscd_pkg::S_IDLE: begin
            req_ready     = 1'b1;
            cmd.host_addr = 1'b1;
            if (accept) begin
               cmd.mem_we = (req_command == gscd_pkg::CMD_LOAD);
               if (req_command == gscd_pkg::CMD_READ) begin
                  cmd.mem_re = 1'b1;
                  cmd.op     = gscd_pkg::OP_HOST_READ;
               end
            end
         end
         gscd_pkg::S_READ_OUT: if (status.out_free) cmd.op = gscd_pkg::OP_READ_DONE;
         gscd_pkg::S_NRM_CLR, gscd_pkg::S_DOT_CLR: cmd.op = gscd_pkg::OP_ACC_CLR;
         gscd_pkg::S_NRM_RD, gscd_pkg::S_NZ_RD: cmd.mem_re = 1'b1;
         gscd_pkg::S_NRM_MUL: cmd.op = gscd_pkg::OP_SQ_MUL;
         gscd_pkg::S_NRM_ACC: cmd.op = gscd_pkg::OP_ACC_SQ;
         gscd_pkg::S_NRM_CMP: cmd.op = gscd_pkg::OP_SQRT_INIT;
         gscd_pkg::S_SQRT:    cmd.op = gscd_pkg::OP_SQRT_STEP;
         gscd_pkg::S_NZ_LOAD: cmd.op = gscd_pkg::OP_DIV_INIT;
         gscd_pkg::S_NZ_DIV:  cmd.op = gscd_pkg::OP_DIV_STEP;
         gscd_pkg::S_NZ_WR: begin
            cmd.mem_we = 1'b1;
            cmd.wsel   = gscd_pkg::WSEL_QUOT;
         end
         gscd_pkg::S_SH_RD: begin
            cmd.mem_re = 1'b1;
            run_addr   = sa_ff + AW'(MAX_ROWS);
         end
         gscd_pkg::S_SH_WR: begin
            cmd.mem_we = 1'b1;
            cmd.wsel   = gscd_pkg::WSEL_SHIFT;
            run_addr   = sa_ff;
         end
         gscd_pkg::S_DOT_RDA, gscd_pkg::S_UP_RDA: begin
            cmd.mem_re = 1'b1;
            run_addr   = addr_j;
         end
         gscd_pkg::S_DOT_RDB, gscd_pkg::S_UP_RDB: begin
            cmd.mem_re = 1'b1;
            cmd.op     = gscd_pkg::OP_CAP_A;
         end
         gscd_pkg::S_DOT_MUL: cmd.op = gscd_pkg::OP_DOT_MUL;
         gscd_pkg::S_DOT_ACC: cmd.op = gscd_pkg::OP_ACC_DOT;
         gscd_pkg::S_COEF:    cmd.op = gscd_pkg::OP_COEF;
         gscd_pkg::S_UP_MUL:  cmd.op = gscd_pkg::OP_UP_MUL;
         gscd_pkg::S_UP_SUB:  cmd.op = gscd_pkg::OP_UP_SUB;
         gscd_pkg::S_UP_WR: begin
            cmd.mem_we = 1'b1;
            cmd.wsel   = gscd_pkg::WSEL_UPDATE;
         end
         gscd_pkg::S_FINISH: if (status.out_free) cmd.op = gscd_pkg::OP_RUN_DONE;
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gscd_pkg::S_IDLE;
         rows_ff  <= gscd_pkg::ROWS_RESET;
         cols_ff  <= gscd_pkg::COLS_RESET;
         r_ff     <= '0;
         c_ff     <= '0;
         m_ff     <= '0;
         k_ff     <= '0;
         j_ff     <= '0;
         i_ff     <= '0;
         cnt_ff   <= '0;
         sa_ff    <= '0;
      end else begin
         state_ff <= state_in;
         rows_ff  <= rows_in;
         cols_ff  <= cols_in;
         r_ff     <= r_in;
         c_ff     <= c_in;
         m_ff     <= m_in;
         k_ff     <= k_in;
         j_ff     <= j_in;
         i_ff     <= i_in;
         cnt_ff   <= cnt_in;
         sa_ff    <= sa_in;
      end
   end

endmodule

>>> hw/rtl/gscd_datapath.sv
module gscd_datapath #(
   parameter int MAX_ROWS = gscd_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = gscd_pkg::DEF_MAX_COLS,
   localparam int DEPTH = MAX_ROWS * MAX_COLS,
   localparam int AW = $clog2(DEPTH),
   localparam int CW = $clog2(MAX_COLS + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gscd_pkg::gscd_cmd_type               cmd,
   input  logic [AW-1:0]                        run_addr,
   input  logic [CW-1:0]                        run_kept,
   input  logic [CW-1:0]                        run_indep,
   output gscd_pkg::gscd_status_type            status,
   input  logic [gscd_pkg::ROW_W-1:0]           row_index,
   input  logic [gscd_pkg::COL_W-1:0]           col_index,
   input  logic signed [gscd_pkg::DATA_W-1:0]   element_value,
   input  logic                                 csr_write_enable,
   input  logic [gscd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gscd_pkg::DATA_W-1:0]          csr_write_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [gscd_pkg::DATA_W-1:0]   read_value,
   output logic [gscd_pkg::COUNT_W-1:0]         kept_columns,
   output logic [gscd_pkg::COUNT_W-1:0]         independent_count,
   output logic                                 rsp_status
);

   logic [31:0] store_mem [DEPTH];

   logic [31:0]        thresh_ff, thresh_in;
   logic [CW-1:0]      kept_ff, kept_in;
   logic [CW-1:0]      indep_ff, indep_in;
   logic signed [31:0] rd_data_ff;
   logic signed [31:0] a_ff, a_in;
   logic signed [31:0] b_ff, b_in;
   logic signed [31:0] t_ff, t_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [63:0]        acc_ff, acc_in;
   logic [63:0]        d_ff, d_in;
   logic [63:0]        sq_x_ff, sq_x_in;
   logic [63:0]        sq_res_ff, sq_res_in;
   logic [63:0]        sq_one_ff, sq_one_in;
   logic               div_neg_ff, div_neg_in;
   logic [55:0]        div_q_ff, div_q_in;
   logic [31:0]        div_rem_ff, div_rem_in;
   logic               rd_err_ff, rd_err_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_value_ff, rsp_value_in;
   logic [5:0]         rsp_kept_ff, rsp_kept_in;
   logic [5:0]         rsp_indep_ff, rsp_indep_in;
   logic               rsp_status_ff, rsp_status_in;

   logic          in_store;
   logic [AW-1:0] host_addr;
   logic [AW-1:0] mem_addr;
   logic          mem_we;
   logic          mem_re;
   logic [31:0]   mem_wdata;
   logic [31:0]   nrm;
   logic [64:0]   usum;
   logic [64:0]   ssum;
   logic [63:0]   sq_sum;
   logic [32:0]   rem_sh;
   logic          rem_ge;
   logic [31:0]   rd_mag;

   // Saturate a sign and magnitude to a signed 32-bit word
   function automatic logic [31:0] sign_sat(input logic neg, input logic [55:0] mag);
      logic [31:0] res;
      if (!neg) begin
         res = (mag > 56'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      end else begin
         res = (mag >= 56'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
      end
      return res;
   endfunction

   // Round Q16.48 to Q8.24, ties away from zero, and saturate
   function automatic logic [31:0] to_q24(input logic [63:0] v);
      logic        neg;
      logic [63:0] mag;
      logic [63:0] rnd;
      neg = v[63];
      mag = neg ? (64'd0 - v) : v;
      rnd = (mag + 64'h80_0000) >> 24;
      return sign_sat(neg, rnd[55:0]);
   endfunction

   assign in_store  = (int'(row_index) < MAX_ROWS) && (int'(col_index) < MAX_COLS);
   assign host_addr = AW'(col_index) * AW'(MAX_ROWS) + AW'(row_index);
   assign mem_addr  = cmd.host_addr ? host_addr : run_addr;
   assign mem_we    = cmd.mem_we && (!cmd.host_addr || in_store);
   assign mem_re    = cmd.mem_re && (!cmd.host_addr || in_store);
   assign nrm       = (sq_res_ff[31:0] == '0) ? 32'd1 : sq_res_ff[31:0];

   assign status.keep     = acc_ff > 64'({thresh_ff, 24'd0});
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign read_value        = rsp_value_ff;
   assign kept_columns      = rsp_kept_ff;
   assign independent_count = rsp_indep_ff;
   assign rsp_status        = rsp_status_ff;

   // Select the memory write data
   always_comb begin
      case (cmd.wsel)
         gscd_pkg::WSEL_HOST:   mem_wdata = element_value;
         gscd_pkg::WSEL_UPDATE: mem_wdata = to_q24(d_ff);
         gscd_pkg::WSEL_QUOT:   mem_wdata = sign_sat(div_neg_ff, div_q_ff);
         gscd_pkg::WSEL_SHIFT:  mem_wdata = rd_data_ff;
         default:               mem_wdata = element_value;
      endcase
   end

   // Matrix store, one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[mem_addr];
      end
   end

   // Threshold register
   always_comb begin
      thresh_in = thresh_ff;
      if (csr_write_enable && csr_index == gscd_pkg::CSR_DROP_THRESHOLD) begin
         thresh_in = csr_write_data;
      end
   end

   // Arithmetic steps
   always_comb begin
      a_in       = a_ff;
      b_in       = b_ff;
      t_in       = t_ff;
      prod_in    = prod_ff;
      acc_in     = acc_ff;
      d_in       = d_ff;
      sq_x_in    = sq_x_ff;
      sq_res_in  = sq_res_ff;
      sq_one_in  = sq_one_ff;
      div_neg_in = div_neg_ff;
      div_q_in   = div_q_ff;
      div_rem_in = div_rem_ff;
      rd_err_in  = rd_err_ff;
      usum       = {1'b0, acc_ff} + {1'b0, prod_ff};
      ssum       = {acc_ff[63], acc_ff} + {prod_ff[63], prod_ff};
      sq_sum     = sq_res_ff + sq_one_ff;
      rem_sh     = {div_rem_ff, div_q_ff[55]};
      rem_ge     = rem_sh >= {1'b0, nrm};
      rd_mag     = rd_data_ff[31] ? (32'd0 - rd_data_ff) : rd_data_ff;
      case (cmd.op)
         gscd_pkg::OP_HOST_READ: begin
            rd_err_in = !(in_store && (int'(col_index) < int'(kept_ff)));
         end
         gscd_pkg::OP_ACC_CLR: acc_in = '0;
         gscd_pkg::OP_SQ_MUL:  prod_in = rd_data_ff * rd_data_ff;
         gscd_pkg::OP_ACC_SQ:  acc_in = usum[64] ? '1 : usum[63:0];
         gscd_pkg::OP_CAP_A:   a_in = rd_data_ff;
         gscd_pkg::OP_DOT_MUL: prod_in = a_ff * rd_data_ff;
         gscd_pkg::OP_ACC_DOT: begin
            if (ssum[64] != ssum[63]) begin
               acc_in = ssum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            end else begin
               acc_in = ssum[63:0];
            end
         end
         gscd_pkg::OP_COEF: t_in = to_q24(acc_ff);
         gscd_pkg::OP_UP_MUL: begin
            prod_in = t_ff * a_ff;
            b_in    = rd_data_ff;
         end
         gscd_pkg::OP_UP_SUB: d_in = {{8{b_ff[31]}}, b_ff, 24'd0} - prod_ff;
         gscd_pkg::OP_SQRT_INIT: begin
            sq_x_in   = acc_ff;
            sq_res_in = '0;
            sq_one_in = 64'h4000_0000_0000_0000;
         end
         gscd_pkg::OP_SQRT_STEP: begin
            if (sq_x_ff >= sq_sum) begin
               sq_x_in   = sq_x_ff - sq_sum;
               sq_res_in = (sq_res_ff >> 1) + sq_one_ff;
            end else begin
               sq_res_in = sq_res_ff >> 1;
            end
            sq_one_in = sq_one_ff >> 2;
         end
         gscd_pkg::OP_DIV_INIT: begin
            div_neg_in = rd_data_ff[31];
            div_q_in   = {rd_mag, 24'd0} + 56'(nrm[31:1]);
            div_rem_in = '0;
         end
         gscd_pkg::OP_DIV_STEP: begin
            div_rem_in = rem_ge ? 32'(rem_sh - {1'b0, nrm}) : rem_sh[31:0];
            div_q_in   = {div_q_ff[54:0], rem_ge};
         end
         default: ;
      endcase
   end

   // Result register and run counts
   always_comb begin
      kept_in       = kept_ff;
      indep_in      = indep_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_kept_in   = rsp_kept_ff;
      rsp_indep_in  = rsp_indep_ff;
      rsp_status_in = rsp_status_ff;
      case (cmd.op)
         gscd_pkg::OP_READ_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = rd_err_ff ? 32'd0 : rd_data_ff;
            rsp_kept_in   = 6'(kept_ff);
            rsp_indep_in  = 6'(indep_ff);
            rsp_status_in = rd_err_ff;
         end
         gscd_pkg::OP_RUN_DONE: begin
            kept_in       = run_kept;
            indep_in      = run_indep;
            rsp_valid_in  = 1'b1;
            rsp_value_in  = '0;
            rsp_kept_in   = 6'(run_kept);
            rsp_indep_in  = 6'(run_indep);
            rsp_status_in = 1'b0;
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= gscd_pkg::THRESH_RESET;
         kept_ff      <= '0;
         indep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         thresh_ff    <= thresh_in;
         kept_ff      <= kept_in;
         indep_ff     <= indep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      b_ff          <= b_in;
      t_ff          <= t_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      d_ff          <= d_in;
      sq_x_ff       <= sq_x_in;
      sq_res_ff     <= sq_res_in;
      sq_one_ff     <= sq_one_in;
      div_neg_ff    <= div_neg_in;
      div_q_ff      <= div_q_in;
      div_rem_ff    <= div_rem_in;
      rd_err_ff     <= rd_err_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_kept_ff   <= rsp_kept_in;
      rsp_indep_ff  <= rsp_indep_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

>>> hw/rtl/gram_schmidt_with_column_drop_unit.sv
// Modified Gram-Schmidt with column drop over a signed Q8.24 matrix held in a
// single-port store of MAX_ROWS x MAX_COLS words. A load item gives no result;
// a read item returns the element, with status 1 and a zero value for a column
// at or beyond the kept count or a position outside the store. A run item holds
// the request channel for the whole run: each earlier kept column is projected
// out (dot product, then element update, all through the one memory port), each
// normalized column takes the squared norm, the bit-serial 64-bit square root
// and the 56-step bit-serial divider for each element, and a dropped column has
// every word of the columns shifted left moved by one read and one write. The
// result of a run carries the kept column count and the independent count.
module gram_schmidt_with_column_drop_unit #(
   parameter int MAX_ROWS = gscd_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = gscd_pkg::DEF_MAX_COLS
) (
   input  logic                            clock,
   input  logic                            reset,
   gscd_req_if.sink                        req_chan,
   gscd_rsp_if.source                      rsp_chan,
   input  logic                            csr_write_enable,
   input  logic [gscd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gscd_pkg::DATA_W-1:0]     csr_write_data
);

   localparam int AW = $clog2(MAX_ROWS * MAX_COLS);
   localparam int CW = $clog2(MAX_COLS + 1);

   gscd_pkg::gscd_cmd_type    cmd;
   gscd_pkg::gscd_status_type status;
   logic [AW-1:0]             run_addr;
   logic [CW-1:0]             run_kept;
   logic [CW-1:0]             run_indep;

   gscd_controller #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_command      (req_chan.command),
      .req_ready        (req_chan.ready),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .status           (status),
      .cmd              (cmd),
      .run_addr         (run_addr),
      .run_kept         (run_kept),
      .run_indep        (run_indep)
   );

   gscd_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .run_addr          (run_addr),
      .run_kept          (run_kept),
      .run_indep         (run_indep),
      .status            (status),
      .row_index         (req_chan.row_index),
      .col_index         (req_chan.col_index),
      .element_value     (req_chan.element_value),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .read_value        (rsp_chan.read_value),
      .kept_columns      (rsp_chan.kept_columns),
      .independent_count (rsp_chan.independent_count),
      .rsp_status        (rsp_chan.status)
   );

   // Independent count never exceeds the kept count
   a_indep_le_kept: assert property (@(posedge clock) disable iff (reset)
      run_kept >= run_indep)
      else $error("independent count above kept count");

   // Kept count stays within the store
   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      int'(run_kept) <= MAX_COLS)
      else $error("kept count beyond column limit");

   // A run holds off the request channel
   a_run_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.command == gscd_pkg::CMD_RUN)
      |=> !req_chan.ready)
      else $error("request accepted during run");

   // An error result carries a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status) |-> (rsp_chan.read_value == 0))
      else $error("error result with nonzero value");

endmodule

>>> verif/tb_gram_schmidt_with_column_drop_unit.sv
module tb_gram_schmidt_with_column_drop_unit;

   localparam int NROWS = gscd_pkg::DEF_MAX_ROWS;
   localparam int NCOLS = gscd_pkg::DEF_MAX_COLS;
   localparam logic [gscd_pkg::CMD_W-1:0] CMD_IGNORED = 2'd3;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      logic [gscd_pkg::CMD_W-1:0]         cmd;
      logic [gscd_pkg::ROW_W-1:0]         row;
      logic [gscd_pkg::COL_W-1:0]         col;
      logic signed [gscd_pkg::DATA_W-1:0] value;
   } matrix_cmd_type;

   typedef struct {
      logic [gscd_pkg::DATA_W-1:0]  read_value;
      logic [gscd_pkg::COUNT_W-1:0] kept;
      logic [gscd_pkg::COUNT_W-1:0] indep;
      logic                         status;
   } reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                           csr_write_enable = 1'b0;
   logic [gscd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [gscd_pkg::DATA_W-1:0]    csr_write_data = '0;

   gscd_req_if req_bus ();
   gscd_rsp_if rsp_bus ();

   gram_schmidt_with_column_drop_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   // Shadow of the block: matrix, counts and registers
   logic signed [31:0] shadow_mat [NROWS][NCOLS];
   int unsigned        shadow_kept;
   int unsigned        shadow_indep;
   logic [4:0]         rows_reg = gscd_pkg::ROWS_RESET;
   logic [5:0]         cols_reg = gscd_pkg::COLS_RESET;
   logic [31:0]        thresh_reg = gscd_pkg::THRESH_RESET;

   matrix_cmd_type cmd_backlog [$];
   reply_type      expected_replies [$];
   int             mismatch_count = 0;
   int unsigned    cycle_count = 0;

   function automatic logic signed [31:0] sat_to_i32(bit neg, bit [63:0] mag);
      if (!neg)
         return (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : mag[31:0];
      if (mag >= 64'h8000_0000)
         return 32'sh8000_0000;
      return -mag[31:0];
   endfunction

   // Q16.48 to Q8.24, round half away from zero, saturate
   function automatic logic signed [31:0] round_q24(longint v);
      bit        neg;
      bit [63:0] mag;
      neg = v < 0;
      mag = neg ? 64'd0 - 64'(v) : 64'(v);
      return sat_to_i32(neg, (mag + 64'd8388608) >> 24);
   endfunction

   function automatic bit [63:0] isqrt_u64(bit [63:0] x);
      bit [63:0] res, one;
      res = 0;
      one = 64'd1 << 62;
      while (one > x) one = one >> 2;
      while (one != 0) begin
         if (x >= res + one) begin
            x   = x - (res + one);
            res = (res >> 1) + one;
         end else begin
            res = res >> 1;
         end
         one = one >> 2;
      end
      return res;
   endfunction

   function automatic bit [63:0] column_energy(int c, int rows);
      bit [63:0] s, p;
      longint    x;
      s = 0;
      for (int i = 0; i < rows; i++) begin
         x = shadow_mat[i][c];
         p = 64'(x * x);
         s = (s > ~64'd0 - p) ? ~64'd0 : s + p;
      end
      return s;
   endfunction

   // Normalize column c when its energy clears the threshold
   function automatic bit normalize_column(int c, int rows);
      bit [63:0] s, nrm, mag;
      bit        neg;
      s = column_energy(c, rows);
      if (s <= (64'(thresh_reg) << 24)) return 1'b0;
      nrm = isqrt_u64(s);
      if (nrm == 0) nrm = 1;
      for (int i = 0; i < rows; i++) begin
         neg = shadow_mat[i][c] < 0;
         mag = neg ? 64'd0 - 64'(longint'(shadow_mat[i][c])) : 64'(shadow_mat[i][c]);
         mag = mag << 24;
         shadow_mat[i][c] = sat_to_i32(neg, (mag + nrm / 2) / nrm);
      end
      return 1'b1;
   endfunction

   function automatic longint add_sat64(longint a, longint b);
      longint r;
      r = a + b;
      if (a >= 0 && b >= 0 && r < 0) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (a < 0 && b < 0 && r >= 0) return 64'sh8000_0000_0000_0000;
      return r;
   endfunction

   function automatic void orthonormalize();
      int     nr, nc, m, k;
      longint acc, t, d;
      nr = (rows_reg < 1) ? 1 : (rows_reg > NROWS ? NROWS : rows_reg);
      nc = (cols_reg < 1) ? 1 : (cols_reg > NCOLS ? NCOLS : cols_reg);
      m  = (nc >= nr) ? nc - nr : 0;
      k  = 1;
      void'(normalize_column(0, nr));
      while (k < nc) begin
         // remove projection onto each earlier kept column
         for (int j = 0; j < k; j++) begin
            acc = 0;
            for (int i = 0; i < nr; i++)
               acc = add_sat64(acc, longint'(shadow_mat[i][j]) * longint'(shadow_mat[i][k]));
            t = round_q24(acc);
            for (int i = 0; i < nr; i++) begin
               d = longint'(shadow_mat[i][k]) * 64'sd16777216 - t * longint'(shadow_mat[i][j]);
               shadow_mat[i][k] = round_q24(d);
            end
         end
         if (normalize_column(k, nr)) begin
            k++;
         end else begin
            // drop column k and shift the rest left
            if (k <= m) m--;
            for (int c = k; c + 1 < nc; c++)
               for (int i = 0; i < NROWS; i++)
                  shadow_mat[i][c] = shadow_mat[i][c + 1];
            nc--;
         end
      end
      shadow_kept  = nc;
      shadow_indep = m;
   endfunction

   function automatic void apply_command(matrix_cmd_type it);
      reply_type r;
      r = '{read_value: '0, kept: '0, indep: '0, status: 1'b0};
      case (it.cmd)
         gscd_pkg::CMD_LOAD: begin
            shadow_mat[it.row][it.col] = it.value;
            return;
         end
         gscd_pkg::CMD_RUN: orthonormalize();
         gscd_pkg::CMD_READ: begin
            if (it.col < shadow_kept) r.read_value = shadow_mat[it.row][it.col];
            else r.status = 1'b1;
         end
         default: return;
      endcase
      r.kept  = shadow_kept[5:0];
      r.indep = shadow_indep[5:0];
      expected_replies.push_back(r);
   endfunction

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 50) $display("[%0d] mismatch: %s", cycle_count, what);
   endtask

   // Driver: bursts of items with random gaps
   matrix_cmd_type cur_cmd;
   int             burst_left = 8;
   int             gap_left = 0;

   initial begin
      req_bus.valid         = 1'b0;
      req_bus.command       = '0;
      req_bus.row_index     = '0;
      req_bus.col_index     = '0;
      req_bus.element_value = '0;
      rsp_bus.ready         = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) apply_command(cur_cmd);
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
               cur_cmd = cmd_backlog.pop_front();
               req_bus.valid         <= 1'b1;
               req_bus.command       <= cur_cmd.cmd;
               req_bus.row_index     <= cur_cmd.row;
               req_bus.col_index     <= cur_cmd.col;
               req_bus.element_value <= cur_cmd.value;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall on a rotating pattern and check each reply
   always @(posedge clock) begin
      reply_type exp_r;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         cycle_count++;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_replies.size() == 0) begin
               report_mismatch("reply with none expected");
            end else begin
               exp_r = expected_replies.pop_front();
               if (rsp_bus.read_value !== exp_r.read_value)
                  report_mismatch($sformatf("read_value %h exp %h",
                                            rsp_bus.read_value, exp_r.read_value));
               if (rsp_bus.kept_columns !== exp_r.kept)
                  report_mismatch($sformatf("kept_columns %0d exp %0d",
                                            rsp_bus.kept_columns, exp_r.kept));
               if (rsp_bus.independent_count !== exp_r.indep)
                  report_mismatch($sformatf("independent_count %0d exp %0d",
                                            rsp_bus.independent_count, exp_r.indep));
               if (rsp_bus.status !== exp_r.status)
                  report_mismatch($sformatf("status %0d exp %0d",
                                            rsp_bus.status, exp_r.status));
            end
         end
         case ((cycle_count / 300) % 3)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(2) != 0);
            default: rsp_bus.ready <= ((cycle_count % 5) < 2);
         endcase
      end
   end

   // Watchdog
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("gram_schmidt_with_column_drop_unit regression: fail");
         $finish;
      end
   end

   task automatic push_cmd(logic [1:0] cmd, int row, int col, logic [31:0] value);
      matrix_cmd_type it;
      it.cmd   = cmd;
      it.row   = row[gscd_pkg::ROW_W-1:0];
      it.col   = col[gscd_pkg::COL_W-1:0];
      it.value = value;
      cmd_backlog.push_back(it);
   endtask

   function automatic logic [31:0] rand_q24();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom;
         3: return 32'h0;
         default: return $urandom_range(32'h03FF_FFFF) - 32'h0200_0000;
      endcase
   endfunction

   // Wait for the block to drain, then leave it idle a while
   task automatic drain();
      do @(negedge clock);
      while (cmd_backlog.size() != 0 || req_bus.valid || expected_replies.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [gscd_pkg::CSR_IDX_W-1:0] idx, logic [31:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         gscd_pkg::CSR_ROWS_IN_USE: rows_reg = data[4:0];
         gscd_pkg::CSR_COLS_IN_USE: cols_reg = data[5:0];
         default:                   thresh_reg = data;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic configure(int rows, int cols, logic [31:0] thresh);
      drain();
      write_reg(gscd_pkg::CSR_ROWS_IN_USE, rows);
      write_reg(gscd_pkg::CSR_COLS_IN_USE, cols);
      write_reg(gscd_pkg::CSR_DROP_THRESHOLD, thresh);
   endtask

   // Load a matrix with some dependent or empty columns, run, read back, add noise
   task automatic solve_sequence();
      int          nr, nc, style, src;
      logic [31:0] v;
      logic [31:0] vals [NROWS][NCOLS];
      nr = (rows_reg < 1) ? 1 : (rows_reg > NROWS ? NROWS : rows_reg);
      nc = (cols_reg < 1) ? 1 : (cols_reg > NCOLS ? NCOLS : cols_reg);
      for (int c = 0; c < nc; c++) begin
         style = $urandom_range(9);
         src   = (c > 0) ? $urandom_range(c - 1) : 0;
         for (int r = 0; r < nr; r++) begin
            if (style < 2 && c > 0) v = vals[r][src];
            else if (style == 2) v = 0;
            else v = rand_q24();
            vals[r][c] = v;
            push_cmd(gscd_pkg::CMD_LOAD, r, c, v);
         end
      end
      push_cmd(gscd_pkg::CMD_RUN, $urandom_range(15), $urandom_range(31), $urandom);
      repeat (8)
         push_cmd(gscd_pkg::CMD_READ, $urandom_range(15), $urandom_range(nc + 1), $urandom);
      // noise, including ignored commands
      repeat (5)
         push_cmd($urandom_range(3), $urandom_range(15), $urandom_range(31), rand_q24());
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Fill the whole store so no read or shift sees an unwritten word
      for (int c = 0; c < NCOLS; c++)
         for (int r = 0; r < NROWS; r++)
            push_cmd(gscd_pkg::CMD_LOAD, r, c, rand_q24());

      // Read before any run, ignored command, corner positions
      push_cmd(gscd_pkg::CMD_READ, 0, 0, 0);
      push_cmd(CMD_IGNORED, 15, 31, 32'hFFFF_FFFF);
      push_cmd(gscd_pkg::CMD_LOAD, 15, 31, 32'h8000_0000);
      push_cmd(gscd_pkg::CMD_LOAD, 0, 0, 32'h7FFF_FFFF);
      push_cmd(gscd_pkg::CMD_READ, 15, 31, 0);

      // Small matrix with a duplicate and an empty column
      configure(3, 4, 17);
      push_cmd(gscd_pkg::CMD_LOAD, 0, 0, 32'h7FFF_FFFF);
      push_cmd(gscd_pkg::CMD_LOAD, 1, 0, 32'h8000_0000);
      push_cmd(gscd_pkg::CMD_LOAD, 2, 0, 32'h0100_0000);
      for (int r = 0; r < 3; r++) begin
         push_cmd(gscd_pkg::CMD_LOAD, r, 2, 0);
         push_cmd(gscd_pkg::CMD_LOAD, r, 3, rand_q24());
      end
      push_cmd(gscd_pkg::CMD_LOAD, 0, 1, 32'h7FFF_FFFF);
      push_cmd(gscd_pkg::CMD_LOAD, 1, 1, 32'h8000_0000);
      push_cmd(gscd_pkg::CMD_LOAD, 2, 1, 32'h0100_0000);
      push_cmd(gscd_pkg::CMD_RUN, 0, 0, 0);
      push_cmd(gscd_pkg::CMD_READ, 0, 0, 0);
      push_cmd(gscd_pkg::CMD_READ, 2, 1, 0);
      push_cmd(gscd_pkg::CMD_READ, 9, 0, 0);
      push_cmd(gscd_pkg::CMD_READ, 15, 31, 0);

      // Register extremes: clamps, fewer columns than rows, full size
      configure(0, 0, 0);
      solve_sequence();
      configure(1, 1, 32'hFFFF_FFFF);
      solve_sequence();
      configure(4, 8, 32'hFFFF_FFFF);
      solve_sequence();
      configure(5, 3, 1000);
      solve_sequence();
      configure(31, 63, 17);
      push_cmd(gscd_pkg::CMD_RUN, 0, 0, 0);
      push_cmd(gscd_pkg::CMD_READ, 0, 0, 0);
      push_cmd(gscd_pkg::CMD_READ, 15, 31, 0);
      configure(16, 32, 32'h0000_0400);
      push_cmd(gscd_pkg::CMD_RUN, 0, 0, 0);

      // Random settings, mostly small shapes
      for (int p = 0; p < 12; p++) begin
         int          nr;
         logic [31:0] th;
         nr = $urandom_range(1, 6);
         case ($urandom_range(3))
            0: th = 0;
            1: th = 17;
            2: th = $urandom_range(1 << 20);
            default: th = $urandom;
         endcase
         configure(nr, $urandom_range(nr > 1 ? nr - 1 : 1, nr + 4), th);
         repeat (3) solve_sequence();
      end

      drain();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && expected_replies.size() == 0)
         $display("gram_schmidt_with_column_drop_unit regression: pass");
      else
         $display("gram_schmidt_with_column_drop_unit regression: fail");
      $finish;
   end

endmodule

>>> gram_schmidt_with_column_drop_unit.f
hw/rtl/gscd_pkg.sv
hw/rtl/gscd_req_if.sv
hw/rtl/gscd_rsp_if.sv
hw/rtl/gscd_controller.sv
hw/rtl/gscd_datapath.sv
hw/rtl/gram_schmidt_with_column_drop_unit.sv
verif/tb_gram_schmidt_with_column_drop_unit.sv
